/* rtl/pcjq_pkg.sv */
package pcjq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 8;
  localparam int LEVEL_W  = 4;
  localparam int LAYER_W  = 11;
  localparam int FACE_W   = 3;
  localparam int LCNT_W   = 5;
  localparam int DIM_W    = 15;
  localparam int DEPTH_W  = 12;
  localparam int PRIO_W   = 8;
  localparam int GEN_W    = 32;
  localparam int STATUS_W = 2;
  localparam int QCOUNT_W = 5;
  localparam int AREA_W   = 2 * DIM_W;
  localparam int COST_W   = AREA_W + DEPTH_W;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TAKE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADLEVEL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic [LEVEL_W-1:0]        level;
    logic [LAYER_W-1:0]        layer;
    logic [FACE_W-1:0]         face;
    logic signed [PRIO_W-1:0]  prio;
    logic [COST_W-1:0]         cost;
    logic [GEN_W-1:0]          tag;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
  } tbl_ctrl_t;

endpackage

/* rtl/pcjq_if.sv */
interface pcjq_req_if;
  logic                                valid;
  logic                                ready;
  logic [pcjq_pkg::FUNC_W-1:0]         func;
  logic [pcjq_pkg::SLOT_W-1:0]         slot;
  logic [pcjq_pkg::LEVEL_W-1:0]        level;
  logic [pcjq_pkg::LAYER_W-1:0]        layer;
  logic [pcjq_pkg::FACE_W-1:0]         face;
  logic [pcjq_pkg::LCNT_W-1:0]         level_count;
  logic [pcjq_pkg::DIM_W-1:0]          width;
  logic [pcjq_pkg::DIM_W-1:0]          height;
  logic [pcjq_pkg::DEPTH_W-1:0]        depth;
  logic signed [pcjq_pkg::PRIO_W-1:0]  priority_req;
  logic [pcjq_pkg::GEN_W-1:0]          generation;

  modport source (
    output valid, func, slot, level, layer, face, level_count, width, height, depth,
           priority_req, generation,
    input  ready
  );
  modport sink (
    input  valid, func, slot, level, layer, face, level_count, width, height, depth,
           priority_req, generation,
    output ready
  );
endinterface

interface pcjq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pcjq_pkg::STATUS_W-1:0]  status;
  logic                           job_valid;
  logic [pcjq_pkg::SLOT_W-1:0]    job_slot;
  logic [pcjq_pkg::LEVEL_W-1:0]   job_level;
  logic [pcjq_pkg::LAYER_W-1:0]   job_layer;
  logic [pcjq_pkg::FACE_W-1:0]    job_face;
  logic [pcjq_pkg::GEN_W-1:0]     job_generation;
  logic [pcjq_pkg::QCOUNT_W-1:0]  queue_count;

  modport source (
    output valid, status, job_valid, job_slot, job_level, job_layer, job_face,
           job_generation, queue_count,
    input  ready
  );
  modport sink (
    input  valid, status, job_valid, job_slot, job_level, job_layer, job_face,
           job_generation, queue_count,
    output ready
  );
endinterface

/* rtl/priority_cost_job_queue_top.sv */
// Insert computes the area (S_MUL) and stores the entry with its cost (S_STORE), then S_DONE
// registers the result; a rejected, empty or unused operation goes straight to S_DONE.
// Take scans the table one entry a cycle through a single compare unit, then
// compacts the entries behind the taken one, one move a cycle; cancel compacts in one pass.
// One transaction at a time; the next is accepted the cycle after the result is registered.
// Reset (rst_ni low, asynchronous) empties the table; entry contents are not cleared.
module priority_cost_job_queue_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcjq_req_if.sink     req_i,
  pcjq_rsp_if.source   rsp_o
);
  import pcjq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_STORE,
    S_SCAN,
    S_SWEEP,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [FUNC_W-1:0]       func_q;
  entry_t                  job_q;
  logic [DIM_W-1:0]        w_q;
  logic [DIM_W-1:0]        h_q;
  logic [DEPTH_W-1:0]      d_q;
  logic [AREA_W-1:0]       area_q;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        rd_q;
  logic [CNT_W-1:0]        rd_d;
  logic [CNT_W-1:0]        wr_q;
  entry_t                  best_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic [STATUS_W-1:0]     status_q;
  logic                    hit_q;

  logic                    rsp_valid_q;
  logic [STATUS_W-1:0]     rsp_status_q;
  logic                    rsp_job_valid_q;
  entry_t                  rsp_job_q;
  logic [QCOUNT_W-1:0]     rsp_count_q;

  tbl_ctrl_t               tbl_ctrl;
  entry_t                  tbl_wdata;
  entry_t                  tbl_rdata;
  entry_t                  store_entry;
  logic                    better;
  logic                    take_sel;
  logic                    scan_last;
  logic [IDX_W-1:0]        next_best;
  logic                    keep;
  logic                    req_fire;
  logic                    rsp_free;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    store_entry      = job_q;
    store_entry.cost = COST_W'(area_q) * COST_W'(d_q);
  end

  assign take_sel  = (rd_q == '0) || better;
  assign next_best = take_sel ? rd_q[IDX_W-1:0] : best_idx_q;
  assign scan_last = (rd_q == count_q - CNT_W'(1));
  assign keep      = !((func_q == FN_CANCEL) && (tbl_rdata.slot == job_q.slot));

  always_comb begin
    rd_d = rd_q;
    if (state_q == S_IDLE) begin
      rd_d = '0;
    end else if (state_q == S_SCAN) begin
      rd_d = scan_last ? CNT_W'(next_best) + CNT_W'(1) : rd_q + CNT_W'(1);
    end else if (state_q == S_SWEEP && rd_q != count_q) begin
      rd_d = rd_q + CNT_W'(1);
    end
  end

  always_comb begin
    tbl_ctrl.we    = 1'b0;
    tbl_ctrl.waddr = wr_q[IDX_W-1:0];
    tbl_ctrl.raddr = rd_d[IDX_W-1:0];
    tbl_wdata      = tbl_rdata;
    if (state_q == S_STORE) begin
      tbl_ctrl.we    = 1'b1;
      tbl_ctrl.waddr = count_q[IDX_W-1:0];
      tbl_wdata      = store_entry;
    end else if (state_q == S_SWEEP && rd_q != count_q) begin
      tbl_ctrl.we = keep;
    end
  end

  pcjq_table u_table (
    .clk_i   (clk_i),
    .ctrl_i  (tbl_ctrl),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  pcjq_rank u_rank (
    .cand_i   (tbl_rdata),
    .best_i   (best_q),
    .better_o (better)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      func_q          <= FN_INSERT;
      job_q           <= '0;
      w_q             <= '0;
      h_q             <= '0;
      d_q             <= '0;
      area_q          <= '0;
      count_q         <= '0;
      rd_q            <= '0;
      wr_q            <= '0;
      best_q          <= '0;
      best_idx_q      <= '0;
      status_q        <= ST_DONE;
      hit_q           <= 1'b0;
      rsp_valid_q     <= 1'b0;
      rsp_status_q    <= ST_DONE;
      rsp_job_valid_q <= 1'b0;
      rsp_job_q       <= '0;
      rsp_count_q     <= '0;
    end else begin
      rd_q <= rd_d;
      if (state_q == S_DONE && rsp_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            func_q      <= req_i.func;
            job_q.slot  <= req_i.slot;
            job_q.level <= req_i.level;
            job_q.layer <= req_i.layer;
            job_q.face  <= req_i.face;
            job_q.prio  <= req_i.priority_req;
            job_q.cost  <= '0;
            job_q.tag   <= req_i.generation;
            w_q         <= req_i.width;
            h_q         <= req_i.height;
            d_q         <= req_i.depth;
            hit_q       <= 1'b0;
            wr_q        <= '0;
            case (req_i.func)
              FN_INSERT: begin
                if ({1'b0, req_i.level} >= req_i.level_count) begin
                  status_q <= ST_BADLEVEL;
                  state_q  <= S_DONE;
                end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
                  status_q <= ST_FULL;
                  state_q  <= S_DONE;
                end else begin
                  status_q <= ST_DONE;
                  state_q  <= S_MUL;
                end
              end
              FN_CANCEL: begin
                status_q <= ST_DONE;
                state_q  <= S_SWEEP;
              end
              FN_TAKE: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                  state_q  <= S_DONE;
                end else begin
                  status_q <= ST_DONE;
                  state_q  <= S_SCAN;
                end
              end
              default: begin
                status_q <= ST_DONE;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          area_q  <= AREA_W'(w_q) * AREA_W'(h_q);
          state_q <= S_STORE;
        end
        S_STORE: begin
          count_q <= count_q + CNT_W'(1);
          state_q <= S_DONE;
        end
        S_SCAN: begin
          if (take_sel) begin
            best_q     <= tbl_rdata;
            best_idx_q <= rd_q[IDX_W-1:0];
          end
          if (scan_last) begin
            hit_q   <= 1'b1;
            wr_q    <= CNT_W'(next_best);
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (rd_q == count_q) begin
            count_q <= wr_q;
            state_q <= S_DONE;
          end else if (keep) begin
            wr_q <= wr_q + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_status_q    <= status_q;
            rsp_job_valid_q <= hit_q;
            rsp_job_q       <= hit_q ? best_q : '0;
            rsp_count_q     <= QCOUNT_W'(count_q);
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.job_valid      = rsp_job_valid_q;
  assign rsp_o.job_slot       = rsp_job_q.slot;
  assign rsp_o.job_level      = rsp_job_q.level;
  assign rsp_o.job_layer      = rsp_job_q.layer;
  assign rsp_o.job_face       = rsp_job_q.face;
  assign rsp_o.job_generation = rsp_job_q.tag;
  assign rsp_o.queue_count    = rsp_count_q;

endmodule

/* rtl/pcjq_table.sv */
module pcjq_table (
  input  logic                 clk_i,
  input  pcjq_pkg::tbl_ctrl_t  ctrl_i,
  input  pcjq_pkg::entry_t     wdata_i,
  output pcjq_pkg::entry_t     rdata_o
);
  import pcjq_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[ctrl_i.waddr] <= wdata_i;
    end
    rdata_q <= mem_q[ctrl_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pcjq_rank.sv */
module pcjq_rank (
  input  pcjq_pkg::entry_t  cand_i,
  input  pcjq_pkg::entry_t  best_i,
  output logic              better_o
);
  import pcjq_pkg::*;

  always_comb begin
    if (cand_i.prio != best_i.prio) begin
      better_o = $signed(cand_i.prio) < $signed(best_i.prio);
    end else begin
      better_o = cand_i.cost < best_i.cost;
    end
  end

endmodule

/* rtl/pcjq_checker.sv */
module pcjq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [pcjq_pkg::STATUS_W-1:0]  status_i,
  input logic                           job_valid_i,
  input logic [pcjq_pkg::SLOT_W-1:0]    job_slot_i,
  input logic [pcjq_pkg::LEVEL_W-1:0]   job_level_i,
  input logic [pcjq_pkg::LAYER_W-1:0]   job_layer_i,
  input logic [pcjq_pkg::FACE_W-1:0]    job_face_i,
  input logic [pcjq_pkg::GEN_W-1:0]     job_generation_i,
  input logic [pcjq_pkg::QCOUNT_W-1:0]  queue_count_i
);
  import pcjq_pkg::*;

  a_job_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && job_valid_i) |-> (status_i == ST_DONE))
    else $error("job returned with non-done status");

  a_no_job_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !job_valid_i) |->
      (job_slot_i == '0 && job_level_i == '0 && job_layer_i == '0 &&
       job_face_i == '0 && job_generation_i == '0))
    else $error("job fields not cleared without a job");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == ST_EMPTY) |-> (queue_count_i == '0 && !job_valid_i))
    else $error("empty status with queued jobs");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == ST_FULL) |-> (queue_count_i == QCOUNT_W'(TABLE_DEPTH)))
    else $error("full status with room left");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(job_generation_i) &&
       $stable(queue_count_i)))
    else $error("stalled result changed");

endmodule

bind priority_cost_job_queue_top pcjq_checker u_pcjq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .job_valid_i      (rsp_o.job_valid),
  .job_slot_i       (rsp_o.job_slot),
  .job_level_i      (rsp_o.job_level),
  .job_layer_i      (rsp_o.job_layer),
  .job_face_i       (rsp_o.job_face),
  .job_generation_i (rsp_o.job_generation),
  .queue_count_i    (rsp_o.queue_count)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import pcjq_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int IDLE_PCT      = 22;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 32;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [SLOT_W-1:0]        slot;
    logic [LEVEL_W-1:0]       level;
    logic [LAYER_W-1:0]       layer;
    logic [FACE_W-1:0]        face;
    logic [LCNT_W-1:0]        level_count;
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
    logic [DEPTH_W-1:0]       depth;
    logic signed [PRIO_W-1:0] prio;
    logic [GEN_W-1:0]         gen;
  } job_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                job_valid;
    logic [SLOT_W-1:0]   slot;
    logic [LEVEL_W-1:0]  level;
    logic [LAYER_W-1:0]  layer;
    logic [FACE_W-1:0]   face;
    logic [GEN_W-1:0]    tag;
    logic [QCOUNT_W-1:0] count;
  } job_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit idle_on;
  bit fill_phase;
  int error_count;
  int stall_cycles;
  entry_t job_table[$];
  job_outcome_t pending_outcomes[$];

  pcjq_req_if job_req ();
  pcjq_rsp_if job_rsp ();

  priority_cost_job_queue_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (job_req),
    .rsp_o  (job_rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Table model: applies one operation and returns the result it must produce.
  function automatic job_outcome_t apply_job_op(input job_req_t r);
    job_outcome_t res;
    entry_t e;
    int best;
    bit better;
    res = '0;
    res.status = ST_DONE;
    case (r.func)
      FN_INSERT: begin
        if (r.level >= r.level_count) begin
          res.status = ST_BADLEVEL;
        end else if (job_table.size() >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          e.slot  = r.slot;
          e.level = r.level;
          e.layer = r.layer;
          e.face  = r.face;
          e.prio  = r.prio;
          e.cost  = COST_W'(r.width) * COST_W'(r.height) * COST_W'(r.depth);
          e.tag   = r.gen;
          job_table.insert(job_table.size(), e);
        end
      end
      FN_CANCEL: begin
        for (int i = job_table.size() - 1; i >= 0; i--) begin
          if (job_table[i].slot == r.slot) job_table.delete(i);
        end
      end
      FN_TAKE: begin
        if (job_table.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < job_table.size(); i++) begin
            if ($signed(job_table[i].prio) != $signed(job_table[best].prio)) begin
              better = $signed(job_table[i].prio) < $signed(job_table[best].prio);
            end else begin
              better = job_table[i].cost < job_table[best].cost;
            end
            if (better) best = i;
          end
          res.job_valid = 1'b1;
          res.slot      = job_table[best].slot;
          res.level     = job_table[best].level;
          res.layer     = job_table[best].layer;
          res.face      = job_table[best].face;
          res.tag       = job_table[best].tag;
          job_table.delete(best);
        end
      end
      default: ;
    endcase
    res.count = QCOUNT_W'(job_table.size());
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    return ($urandom_range(1) == 0) ? DIM_W'($urandom_range(0, 3)) : DIM_W'($urandom);
  endfunction

  function automatic job_req_t random_fields();
    job_req_t r;
    int lc;
    lc = $urandom_range(1, 31);
    r.func        = FN_INSERT;
    r.slot        = ($urandom_range(99) < 70) ? SLOT_W'($urandom_range(0, 7)) : SLOT_W'($urandom);
    r.level_count = LCNT_W'(lc);
    r.level       = LEVEL_W'($urandom_range(0, (lc > 16) ? 15 : lc - 1));
    r.layer       = LAYER_W'($urandom);
    r.face        = FACE_W'($urandom);
    r.width       = random_dim();
    r.height      = random_dim();
    r.depth       = ($urandom_range(1) == 0) ? DEPTH_W'($urandom_range(0, 3)) : DEPTH_W'($urandom);
    r.prio        = ($urandom_range(1) == 0) ? PRIO_W'(int'($urandom_range(0, 4)) - 2)
                                             : PRIO_W'($urandom);
    r.gen         = $urandom;
    return r;
  endfunction

  function automatic job_req_t random_insert(input bit good);
    job_req_t r;
    int lc;
    r = random_fields();
    if (!good) begin
      lc = $urandom_range(0, 15);
      r.level_count = LCNT_W'(lc);
      r.level       = LEVEL_W'($urandom_range(lc, 15));
    end
    return r;
  endfunction

  function automatic job_req_t make_op(input logic [FUNC_W-1:0] func,
                                       input logic [SLOT_W-1:0] slot);
    job_req_t r;
    r = random_fields();
    r.func = func;
    r.slot = slot;
    return r;
  endfunction

  function automatic job_req_t make_insert(
    input logic [SLOT_W-1:0] slot, input logic [LEVEL_W-1:0] level,
    input logic [LAYER_W-1:0] layer, input logic [FACE_W-1:0] face,
    input logic [LCNT_W-1:0] level_count, input logic [DIM_W-1:0] width,
    input logic [DIM_W-1:0] height, input logic [DEPTH_W-1:0] depth,
    input logic signed [PRIO_W-1:0] prio, input logic [GEN_W-1:0] gen);
    job_req_t r;
    r = '{FN_INSERT, slot, level, layer, face, level_count, width, height, depth, prio, gen};
    return r;
  endfunction

  function automatic job_req_t random_op();
    job_req_t r;
    int pick;
    r = random_fields();
    pick = $urandom_range(99);
    if (pick < 3) begin
      r.func = FN_UNUSED;
    end else if (pick < 10) begin
      r = random_insert(1'b0);
    end else if (pick < 20) begin
      r.func = FN_CANCEL;
    end else if (($urandom_range(99) < 80) != fill_phase) begin
      r.func = FN_TAKE;
    end
    return r;
  endfunction

  task automatic send_job(input job_req_t r);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      job_req.valid <= 1'b0;
      @(negedge clk);
    end
    job_req.valid        <= 1'b1;
    job_req.func         <= r.func;
    job_req.slot         <= r.slot;
    job_req.level        <= r.level;
    job_req.layer        <= r.layer;
    job_req.face         <= r.face;
    job_req.level_count  <= r.level_count;
    job_req.width        <= r.width;
    job_req.height       <= r.height;
    job_req.depth        <= r.depth;
    job_req.priority_req <= r.prio;
    job_req.generation   <= r.gen;
    @(posedge clk);
    while (job_req.ready !== 1'b1) @(posedge clk);
    pending_outcomes.insert(pending_outcomes.size(), apply_job_op(r));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    job_req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_job(make_op(FN_TAKE, 8'd0));
    send_job(make_op(FN_CANCEL, 8'd9));
    send_job(make_op(FN_UNUSED, 8'd0));
    send_job(make_insert(8'd1, 4'd0, 11'd0, 3'd0, 5'd0, 15'd1, 15'd1, 12'd1, 8'sd0, 32'h1));
    send_job(make_insert(8'd1, 4'd15, 11'd7, 3'd2, 5'd15, 15'd1, 15'd1, 12'd1, 8'sd0, 32'h2));
    wait_drained();
  endtask

  task automatic test_ordering();
    send_job(make_insert(8'd255, 4'd15, 11'd2047, 3'd7, 5'd31, 15'h7fff, 15'h7fff, 12'hfff,
                         8'sd127, 32'hffff_ffff));
    send_job(make_insert(8'd0, 4'd0, 11'd0, 3'd0, 5'd1, 15'd0, 15'd5, 12'd5, 8'sd127, 32'h0));
    send_job(make_insert(8'd3, 4'd2, 11'd100, 3'd1, 5'd16, 15'd1, 15'd1, 12'd1, 8'sh80,
                         32'h1111_0001));
    send_job(make_insert(8'd3, 4'd2, 11'd101, 3'd2, 5'd16, 15'd1, 15'd1, 12'd1, 8'sh80,
                         32'h1111_0002));
    send_job(make_insert(8'd4, 4'd0, 11'd5, 3'd5, 5'd2, 15'd5, 15'd0, 12'd9, 8'sh80,
                         32'h2222_0000));
    send_job(make_insert(8'd5, 4'd15, 11'd1024, 3'd6, 5'd16, 15'd300, 15'd200, 12'd1, 8'sd0,
                         32'h3333_0000));
    send_job(make_op(FN_UNUSED, 8'd0));
    send_job(make_op(FN_CANCEL, 8'd7));
    // zero cost wins the priority tie, then the older of two equal jobs
    send_job(make_op(FN_TAKE, 8'd0));
    send_job(make_op(FN_TAKE, 8'd0));
    send_job(make_insert(8'd3, 4'd1, 11'd9, 3'd4, 5'd2, 15'd2, 15'd2, 12'd2, 8'sh80,
                         32'h1111_0003));
    send_job(make_op(FN_CANCEL, 8'd3));
    send_job(make_op(FN_TAKE, 8'd0));
    send_job(make_op(FN_TAKE, 8'd0));
    send_job(make_op(FN_TAKE, 8'd0));
    send_job(make_op(FN_TAKE, 8'd0));
    wait_drained();
  endtask

  task automatic test_full_table();
    while (job_table.size() < TABLE_DEPTH) send_job(random_insert(1'b1));
    send_job(random_insert(1'b1));
    send_job(random_insert(1'b0));
    send_job(make_op(FN_UNUSED, 8'd0));
    while (job_table.size() != 0) send_job(make_op(FN_TAKE, SLOT_W'($urandom)));
    send_job(make_op(FN_TAKE, 8'd0));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle);
    idle_on = with_idle;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(39) == 0) fill_phase = !fill_phase;
      send_job(random_op());
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  // sender holds off until every result is back, then resumes
  task automatic test_paused_sender();
    repeat (5) begin
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(29) == 0) fill_phase = !fill_phase;
        send_job(random_op());
      end
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    job_rsp.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    job_outcome_t got;
    job_outcome_t want;
    if (rst_n && job_rsp.valid === 1'b1 && job_rsp.ready === 1'b1) begin
      got = '{job_rsp.status, job_rsp.job_valid, job_rsp.job_slot, job_rsp.job_level,
              job_rsp.job_layer, job_rsp.job_face, job_rsp.job_generation,
              job_rsp.queue_count};
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending, status", got.status, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.job_valid !== want.job_valid) begin
          report_mismatch("job_valid", got.job_valid, want.job_valid);
        end
        if (got.slot !== want.slot) report_mismatch("job_slot", got.slot, want.slot);
        if (got.level !== want.level) report_mismatch("job_level", got.level, want.level);
        if (got.layer !== want.layer) report_mismatch("job_layer", got.layer, want.layer);
        if (got.face !== want.face) report_mismatch("job_face", got.face, want.face);
        if (got.tag !== want.tag) report_mismatch("job_generation", got.tag, want.tag);
        if (got.count !== want.count) report_mismatch("queue_count", got.count, want.count);
      end
    end
  end

  always @(posedge clk) begin
    if ((job_req.valid === 1'b1 && job_req.ready === 1'b1) ||
        (job_rsp.valid === 1'b1 && job_rsp.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    job_req.valid        = 1'b0;
    job_req.func         = FN_INSERT;
    job_req.slot         = '0;
    job_req.level        = '0;
    job_req.layer        = '0;
    job_req.face         = '0;
    job_req.level_count  = '0;
    job_req.width        = '0;
    job_req.height       = '0;
    job_req.depth        = '0;
    job_req.priority_req = '0;
    job_req.generation   = '0;
    idle_on              = 1'b1;
    fill_phase           = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_ordering();
    test_full_table();
    test_random_traffic(600, 1'b1);
    test_random_traffic(400, 1'b0);
    test_paused_sender();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      report_mismatch("results never returned", pending_outcomes.size(), 0);
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pcjq_pkg.sv
rtl/pcjq_if.sv
rtl/pcjq_table.sv
rtl/pcjq_rank.sv
rtl/priority_cost_job_queue_top.sv
rtl/pcjq_checker.sv
tb/testbench.sv
